// File: rtl/core/rcl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcl_pkg
// Shared types and constants of the remote command link with failsafe.
// ----------------------------------------------------------------------------
package rcl_pkg;

    // frame bytes
    localparam logic [7:0] START_MARK     = 8'hFF;
    localparam logic [7:0] TYPE_FWD       = 8'd3;
    localparam logic [7:0] TYPE_REV       = 8'd4;
    localparam logic [7:0] TYPE_STEER     = 8'd5;
    localparam logic [7:0] TYPE_RANGE_ON  = 8'd6;
    localparam logic [7:0] TYPE_RANGE_OFF = 8'd7;

    // bytes taken from the receive queue
    localparam logic [2:0] CONSUMED_NONE  = 3'd0;
    localparam logic [2:0] CONSUMED_ONE   = 3'd1;
    localparam logic [2:0] CONSUMED_FRAME = 3'd4;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_TIMEOUT   = 2'd0,
        CFG_PERIOD    = 2'd1,
        CFG_RANGE_CAP = 2'd2,
        CFG_CENTER    = 2'd3
    } t_cfg_idx;

    localparam logic [15:0] TIMEOUT_RESET   = 16'd1500;
    localparam logic [15:0] PERIOD_RESET    = 16'd100;
    localparam logic [7:0]  RANGE_CAP_RESET = 8'd250;
    localparam logic [7:0]  CENTER_RESET    = 8'd90;

    // pulse / 147 == (pulse * INCH_RECIP) >> INCH_SHIFT for any 16-bit pulse
    localparam logic [16:0] INCH_RECIP = 17'd57066;
    localparam int          INCH_SHIFT = 23;
    // above this many inches the distance exceeds 255 cm and is always capped
    localparam logic [6:0]  INCH_CLAMP = 7'd101;
    // v / 50 == (v * CM_RECIP) >> CM_SHIFT for v <= 127 * INCH_CLAMP
    localparam logic [12:0] CM_RECIP   = 13'd5243;
    localparam int          CM_SHIFT   = 18;

    typedef struct packed {
        logic       head_ready;
        logic [7:0] head_byte0;
        logic [7:0] head_byte1;
        logic [7:0] head_byte2;
        logic [7:0] head_byte3;
        logic [6:0] inches;
    } t_tick;

    typedef struct packed {
        logic [2:0] bytes_consumed;
        logic       echo_valid;
        logic [7:0] echo_type;
        logic [7:0] echo_data;
        logic [7:0] echo_stop;
        logic       report_valid;
        logic [7:0] report_cm;
        logic [7:0] drive_speed;
        logic       drive_reverse;
        logic [7:0] steer_angle;
        logic       ranging_on;
    } t_result;

endpackage

// File: rtl/core/rcl_tick_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcl_tick_if
// Input channel: one control tick with queue head bytes and sonar pulse.
// ----------------------------------------------------------------------------
interface rcl_tick_if;
    logic        valid;
    logic        ready;
    logic        head_ready;
    logic [7:0]  head_byte0;
    logic [7:0]  head_byte1;
    logic [7:0]  head_byte2;
    logic [7:0]  head_byte3;
    logic [15:0] pulse_us;

    modport source (
        output valid, head_ready, head_byte0, head_byte1, head_byte2, head_byte3,
               pulse_us,
        input  ready
    );
    modport sink (
        input  valid, head_ready, head_byte0, head_byte1, head_byte2, head_byte3,
               pulse_us,
        output ready
    );
endinterface

// File: rtl/core/rcl_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcl_result_if
// Output channel: per-tick echo, distance report and applied drive values.
// ----------------------------------------------------------------------------
interface rcl_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] bytes_consumed;
    logic       echo_valid;
    logic [7:0] echo_type;
    logic [7:0] echo_data;
    logic [7:0] echo_stop;
    logic       report_valid;
    logic [7:0] report_cm;
    logic [7:0] drive_speed;
    logic       drive_reverse;
    logic [7:0] steer_angle;
    logic       ranging_on;

    modport source (
        output valid, bytes_consumed, echo_valid, echo_type, echo_data, echo_stop,
               report_valid, report_cm, drive_speed, drive_reverse, steer_angle,
               ranging_on,
        input  ready
    );
    modport sink (
        input  valid, bytes_consumed, echo_valid, echo_type, echo_data, echo_stop,
               report_valid, report_cm, drive_speed, drive_reverse, steer_angle,
               ranging_on,
        output ready
    );
endinterface

// File: rtl/core/remote_command_link_with_failsafe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// remote_command_link_with_failsafe
// Command frame decoder, sonar range reporter and link-loss failsafe.
// ----------------------------------------------------------------------------
// Each accepted tick yields one result; a new tick is taken
// every cycle while the result side keeps up. The tick is captured in an input
// register (the sonar pulse is already scaled to inches there), then frame
// decode, counters and the distance conversion run in one pass into the result
// register, which also holds while the sink stalls. Config writes go to
// i_cfg_idx 0 timeout, 1 report period, 2 range cap, 3 center angle, and are
// to be made only while no tick is in flight.
module remote_command_link_with_failsafe
    import rcl_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_data,
    rcl_tick_if.sink     i_tick,
    rcl_result_if.source o_res
);

    // configuration
    logic [15:0] r_timeout;
    logic [15:0] r_period;
    logic [7:0]  r_range_cap;
    logic [7:0]  r_center;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= TIMEOUT_RESET;
            r_period    <= PERIOD_RESET;
            r_range_cap <= RANGE_CAP_RESET;
            r_center    <= CENTER_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_TIMEOUT:   r_timeout   <= i_cfg_data;
                CFG_PERIOD:    r_period    <= i_cfg_data;
                CFG_RANGE_CAP: r_range_cap <= i_cfg_data[7:0];
                CFG_CENTER:    r_center    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // input stage
    logic        r_s1_valid;
    t_tick       r_s1;
    logic        r_out_valid;
    t_result     r_out;
    logic        s1_go;
    logic        in_xfer;
    logic [32:0] inch_prod;
    logic [9:0]  inch_full;
    logic [6:0]  inch_clamped;

    assign s1_go        = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_tick.ready = !r_s1_valid || s1_go;
    assign in_xfer      = i_tick.valid && i_tick.ready;

    assign inch_prod    = i_tick.pulse_us * INCH_RECIP;
    assign inch_full    = inch_prod[32:INCH_SHIFT];
    assign inch_clamped = (inch_full > {3'd0, INCH_CLAMP}) ? INCH_CLAMP : inch_full[6:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_tick.ready) begin
            r_s1_valid <= i_tick.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1.head_ready <= i_tick.head_ready;
            r_s1.head_byte0 <= i_tick.head_byte0;
            r_s1.head_byte1 <= i_tick.head_byte1;
            r_s1.head_byte2 <= i_tick.head_byte2;
            r_s1.head_byte3 <= i_tick.head_byte3;
            r_s1.inches     <= inch_clamped;
        end
    end

    // control state
    logic [15:0] r_rep_cnt, n_rep_cnt;
    logic        r_ranging, n_ranging;
    logic [15:0] r_silence, n_silence;
    logic [7:0]  r_mem_speed, n_mem_speed;
    logic [7:0]  r_mem_angle, n_mem_angle;
    logic [7:0]  r_speed, n_speed;
    logic        r_reverse, n_reverse;
    logic [7:0]  r_angle, n_angle;
    t_result     n_out;

    logic        frame;
    logic        report_hit;
    logic        failsafe;
    logic [15:0] silence_inc;
    logic [7:0]  dist_cm;

    rcl_dist u_dist (
        .i_inches    (r_s1.inches),
        .i_range_cap (r_range_cap),
        .o_cm        (dist_cm)
    );

    always_comb begin
        frame       = r_s1.head_ready && (r_s1.head_byte0 == START_MARK);
        report_hit  = r_ranging && (r_rep_cnt == r_period);
        silence_inc = (r_silence == 16'hFFFF) ? r_silence : r_silence + 16'd1;
        failsafe    = !frame && (silence_inc >= r_timeout);

        n_rep_cnt   = r_rep_cnt;
        if (r_ranging) begin
            n_rep_cnt = (report_hit ? 16'd0 : r_rep_cnt) + 16'd1;
        end

        n_ranging   = r_ranging;
        n_mem_speed = r_mem_speed;
        n_mem_angle = r_mem_angle;
        n_speed     = r_speed;
        n_reverse   = r_reverse;
        n_angle     = r_angle;
        n_silence   = silence_inc;

        if (frame) begin
            n_silence = 16'd0;
            case (r_s1.head_byte1)
                TYPE_FWD, TYPE_REV: begin
                    if (r_mem_speed != r_s1.head_byte2) begin
                        n_speed     = r_s1.head_byte2;
                        n_reverse   = (r_s1.head_byte1 == TYPE_REV);
                        n_mem_speed = r_s1.head_byte2;
                    end
                end
                TYPE_STEER: begin
                    if (r_mem_angle != r_s1.head_byte2) begin
                        n_angle     = r_s1.head_byte2;
                        n_mem_angle = r_s1.head_byte2;
                    end
                end
                TYPE_RANGE_ON:  n_ranging = 1'b1;
                TYPE_RANGE_OFF: n_ranging = 1'b0;
                default: ;
            endcase
        end else if (failsafe) begin
            // remembered values stay, so a repeat command after recovery is ignored
            n_speed   = 8'd0;
            n_reverse = 1'b0;
            n_angle   = r_center;
            n_ranging = 1'b0;
        end

        if (frame) begin
            n_out.bytes_consumed = CONSUMED_FRAME;
        end else if (r_s1.head_ready) begin
            n_out.bytes_consumed = CONSUMED_ONE;
        end else begin
            n_out.bytes_consumed = CONSUMED_NONE;
        end
        n_out.echo_valid    = frame;
        n_out.echo_type     = frame ? r_s1.head_byte1 : 8'd0;
        n_out.echo_data     = frame ? r_s1.head_byte2 : 8'd0;
        n_out.echo_stop     = frame ? r_s1.head_byte3 : 8'd0;
        n_out.report_valid  = report_hit;
        n_out.report_cm     = report_hit ? dist_cm : 8'd0;
        n_out.drive_speed   = n_speed;
        n_out.drive_reverse = n_reverse;
        n_out.steer_angle   = n_angle;
        n_out.ranging_on    = n_ranging;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rep_cnt   <= 16'd0;
            r_ranging   <= 1'b0;
            r_silence   <= 16'd0;
            r_mem_speed <= 8'd0;
            r_mem_angle <= 8'd0;
            r_speed     <= 8'd0;
            r_reverse   <= 1'b0;
            r_angle     <= CENTER_RESET;
        end else if (s1_go) begin
            r_rep_cnt   <= n_rep_cnt;
            r_ranging   <= n_ranging;
            r_silence   <= n_silence;
            r_mem_speed <= n_mem_speed;
            r_mem_angle <= n_mem_angle;
            r_speed     <= n_speed;
            r_reverse   <= n_reverse;
            r_angle     <= n_angle;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.bytes_consumed = r_out.bytes_consumed;
    assign o_res.echo_valid     = r_out.echo_valid;
    assign o_res.echo_type      = r_out.echo_type;
    assign o_res.echo_data      = r_out.echo_data;
    assign o_res.echo_stop      = r_out.echo_stop;
    assign o_res.report_valid   = r_out.report_valid;
    assign o_res.report_cm      = r_out.report_cm;
    assign o_res.drive_speed    = r_out.drive_speed;
    assign o_res.drive_reverse  = r_out.drive_reverse;
    assign o_res.steer_angle    = r_out.steer_angle;
    assign o_res.ranging_on     = r_out.ranging_on;

    // checks
    a_report_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go && n_out.report_valid |-> n_out.report_cm <= r_range_cap)
        else $error("report distance above cap");

    a_failsafe_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go && failsafe |=> r_speed == 8'd0 && !r_reverse && !r_ranging)
        else $error("failsafe did not stop the drive");

    a_frame_clears_silence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go && frame |=> r_silence == 16'd0)
        else $error("frame did not clear the silence counter");

    a_echo_consumed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.echo_valid == (r_out.bytes_consumed == CONSUMED_FRAME))
        else $error("echo and consumed byte count disagree");

    a_stage_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_go |=> r_s1_valid && r_out_valid)
        else $error("stalled tick lost");

endmodule

// File: rtl/core/rcl_dist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcl_dist
// Inches to capped centimetres: min(floor(inches * 127 / 50), range cap).
// ----------------------------------------------------------------------------
module rcl_dist
    import rcl_pkg::*;
(
    input  logic [6:0] i_inches,
    input  logic [7:0] i_range_cap,
    output logic [7:0] o_cm
);

    logic [13:0] scaled;
    logic [26:0] prod;
    logic [8:0]  cm_raw;

    // x * 127 = x * 128 - x
    assign scaled = {i_inches, 7'd0} - {7'd0, i_inches};
    assign prod   = scaled * CM_RECIP;
    assign cm_raw = prod[26:CM_SHIFT];
    assign o_cm   = (cm_raw > {1'b0, i_range_cap}) ? i_range_cap : cm_raw[7:0];

endmodule
